/* src/cc20_pkg.sv */
// Shared types, constants and block-function helpers for the ChaCha20 stream cipher.
package cc20_pkg;

  // Default number of double rounds in the block function.
  localparam int DOUBLE_ROUNDS_DEF = 10;

  // Depth of the queue between front and back; a power of two.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Configuration register indexes (paddr[5:3]).
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_NONCE_L = 3'd4;
  localparam logic [2:0] REG_NONCE_H = 3'd5;
  localparam logic [2:0] REG_CTR     = 3'd6;

  // The four constant words of the initial state.
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [3:0][63:0]  key_t;

  // One input beat as it waits in the queue.
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } item_t;

  // Request from the back end to the block core.
  typedef struct packed {
    logic  start;
    word_t counter;
  } core_req_t;

  // Status from the block core.
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  // Four words touched by one quarter round.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // One half of a quarter round: the first half rotates by 16 and 12,
  // the second half by 8 and 7.
  function automatic qr_t half_qr(input word_t a, input word_t b, input word_t c,
                                  input word_t d, input logic second);
    word_t na;
    word_t nd;
    word_t nc;
    word_t nb;
    qr_t   r;
    na = a + b;
    nd = second ? rotl(d ^ na, 8) : rotl(d ^ na, 16);
    nc = c + nd;
    nb = second ? rotl(b ^ nc, 7) : rotl(b ^ nc, 12);
    r.a = na;
    r.b = nb;
    r.c = nc;
    r.d = nd;
    return r;
  endfunction

  // Initial state from constants, key, counter and nonce.
  function automatic block_t build_init(input key_t key, input logic [63:0] nonce_lo,
                                        input word_t nonce_hi, input word_t counter);
    block_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2 * i] = key[i][31:0];
      s[5 + 2 * i] = key[i][63:32];
    end
    s[12] = counter;
    s[13] = nonce_lo[31:0];
    s[14] = nonce_lo[63:32];
    s[15] = nonce_hi;
    return s;
  endfunction

endpackage

/* src/cc20_queue.sv */
// Front end: accepts input beats and queues them with their restart flag.
module cc20_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cc20_pkg::item_t in_item,
  output logic           q_valid,
  output cc20_pkg::item_t q_item,
  input  logic           q_pop
);
  import cc20_pkg::*;

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            push;

  assign in_ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // Storage; pointers wrap naturally because the depth is a power of two.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* src/cc20_core.sv */
// Block function: iterative double rounds, half a quarter round per cycle on four lanes.
module cc20_core #(
  parameter int DOUBLE_ROUND_COUNT = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cc20_pkg::core_req_t   req,
  input  cc20_pkg::key_t        key,
  input  logic [63:0]           nonce_lo,
  input  logic [31:0]           nonce_hi,
  output cc20_pkg::core_stat_t  stat,
  output cc20_pkg::block_t      words
);
  import cc20_pkg::*;

  localparam int STEPS  = 4 * DOUBLE_ROUND_COUNT;
  localparam int STEP_W = $clog2(STEPS + 1);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_ADD   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  word_t             ctr_r, ctr_nxt;
  block_t            w_r, w_nxt;
  block_t            init_w;
  block_t            round_w;
  logic              second_half;
  logic              diag;

  assign second_half = step_r[0];
  assign diag        = step_r[1];
  assign init_w      = build_init(key, nonce_lo, nonce_hi,
                                  (state_r == C_IDLE) ? req.counter : ctr_r);

  // Four quarter-round lanes, column or diagonal selection.
  always_comb begin
    qr_t col;
    qr_t dia;
    round_w = w_r;
    for (int i = 0; i < 4; i++) begin
      col = half_qr(w_r[i], w_r[4 + i], w_r[8 + i], w_r[12 + i], second_half);
      dia = half_qr(w_r[i], w_r[4 + ((i + 1) % 4)], w_r[8 + ((i + 2) % 4)],
                    w_r[12 + ((i + 3) % 4)], second_half);
      if (diag) begin
        round_w[i]                  = dia.a;
        round_w[4 + ((i + 1) % 4)]  = dia.b;
        round_w[8 + ((i + 2) % 4)]  = dia.c;
        round_w[12 + ((i + 3) % 4)] = dia.d;
      end else begin
        round_w[i]      = col.a;
        round_w[4 + i]  = col.b;
        round_w[8 + i]  = col.c;
        round_w[12 + i] = col.d;
      end
    end
  end

  // Sequencer: load, run the rounds, add the input back in.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctr_nxt   = ctr_r;
    w_nxt     = w_r;
    case (state_r)
      C_IDLE: begin
        if (req.start) begin
          ctr_nxt   = req.counter;
          w_nxt     = init_w;
          step_nxt  = '0;
          state_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        w_nxt    = round_w;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = C_ADD;
        end
      end
      C_ADD: begin
        for (int i = 0; i < 16; i++) begin
          w_nxt[i] = w_r[i] + init_w[i];
        end
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r <= ctr_nxt;
    w_r   <= w_nxt;
  end

  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = (state_r == C_ADD);
  assign words     = w_r;

endmodule

/* src/cc20_back.sv */
// Back end: keystream position and block counter, block requests and the output register.
module cc20_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  cc20_pkg::item_t      q_item,
  output logic                 q_pop,
  input  logic [31:0]          start_counter,
  output cc20_pkg::core_req_t  core_req,
  input  cc20_pkg::core_stat_t core_stat,
  input  cc20_pkg::block_t     ks_words,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_data
);
  import cc20_pkg::*;

  localparam logic B_WAIT = 1'b0;
  localparam logic B_GEN  = 1'b1;

  logic       state_r, state_nxt;
  word_t      ctr_r, ctr_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic       handled_r, handled_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       fresh_restart;
  logic       need_block;
  logic       out_free;
  word_t      ks_word;
  logic [7:0] ks_byte;

  // A restart flag counts once: handled_r marks that its block is made.
  assign fresh_restart = q_item.restart && !handled_r;
  assign need_block    = fresh_restart || pos_r[6];
  assign out_free      = !out_valid_r || out_ready;
  assign ks_word       = ks_words[pos_r[5:2]];
  assign ks_byte       = ks_word[{pos_r[1:0], 3'b000} +: 8];

  always_comb begin
    state_nxt        = state_r;
    ctr_nxt          = ctr_r;
    pos_nxt          = pos_r;
    handled_nxt      = handled_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    q_pop            = 1'b0;
    core_req.start   = 1'b0;
    core_req.counter = fresh_restart ? start_counter : ctr_r;
    case (state_r)
      B_WAIT: begin
        if (q_valid) begin
          if (need_block) begin
            core_req.start = 1'b1;
            ctr_nxt        = core_req.counter + 32'd1;
            state_nxt      = B_GEN;
          end else if (out_free) begin
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            out_data_nxt  = q_item.data ^ ks_byte;
            pos_nxt       = pos_r + 7'd1;
            handled_nxt   = 1'b0;
          end
        end
      end
      B_GEN: begin
        if (core_stat.done) begin
          pos_nxt     = '0;
          handled_nxt = 1'b1;
          state_nxt   = B_WAIT;
        end
      end
      default: state_nxt = B_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_WAIT;
      ctr_r       <= '0;
      pos_r       <= 7'd64;
      handled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      pos_r       <= pos_nxt;
      handled_r   <= handled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/chacha20_stream_cipher.sv */
// Top level of the ChaCha20 byte stream cipher: register file, queue, back end and block core.
//
//  Channel | Ports                            | Beat contents
//  --------+----------------------------------+-----------------------------------------
//  input   | in_tvalid/in_tready/in_tdata     | tdata: data_byte[7:0]; tuser: restart
//  output  | out_tvalid/out_tready/out_tdata  | tdata: out_byte[7:0]
//  config  | cfg_psel ... cfg_pready          | 64-bit registers at byte address 8*index
//
// A byte from an available 64-byte block leaves through the output register when that is free.
// A new block, needed after 64 bytes or on a restart, stalls the stream while
// the iterative round unit makes it.
// Reset is synchronous and active low; it empties the queue and marks the buffer as used up.
// A four-beat queue lets the input keep accepting while the output or the core stalls.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUND_COUNT = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import cc20_pkg::*;

  key_t        key_r;
  logic [63:0] nonce_lo_r;
  word_t       nonce_hi_r;
  word_t       start_ctr_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  item_t       in_item;
  item_t       q_item;
  logic        q_valid;
  logic        q_pop;
  core_req_t   core_req;
  core_stat_t  core_stat;
  block_t      ks_words;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_ctr_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY0:    key_r[0]    <= cfg_pwdata;
        REG_KEY1:    key_r[1]    <= cfg_pwdata;
        REG_KEY2:    key_r[2]    <= cfg_pwdata;
        REG_KEY3:    key_r[3]    <= cfg_pwdata;
        REG_NONCE_L: nonce_lo_r  <= cfg_pwdata;
        REG_NONCE_H: nonce_hi_r  <= cfg_pwdata[31:0];
        REG_CTR:     start_ctr_r <= cfg_pwdata[31:0];
        default:     ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_KEY0:    cfg_prdata = key_r[0];
      REG_KEY1:    cfg_prdata = key_r[1];
      REG_KEY2:    cfg_prdata = key_r[2];
      REG_KEY3:    cfg_prdata = key_r[3];
      REG_NONCE_L: cfg_prdata = nonce_lo_r;
      REG_NONCE_H: cfg_prdata = {32'd0, nonce_hi_r};
      REG_CTR:     cfg_prdata = {32'd0, start_ctr_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_item.restart = in_tuser;
  assign in_item.data    = in_tdata;

  cc20_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  cc20_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .start_counter (start_ctr_r),
    .core_req      (core_req),
    .core_stat     (core_stat),
    .ks_words      (ks_words),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_tdata)
  );

  cc20_core #(
    .DOUBLE_ROUND_COUNT (DOUBLE_ROUND_COUNT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (core_req),
    .key      (key_r),
    .nonce_lo (nonce_lo_r),
    .nonce_hi (nonce_hi_r),
    .stat     (core_stat),
    .words    (ks_words)
  );

`ifndef SYNTHESIS
  // A block is requested only while the core is free.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    core_req.start |-> !core_stat.busy)
    else $error("block requested while core busy");

  // The back end takes a beat only from a non-empty queue and never while a block is made.
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && !core_stat.busy))
    else $error("queue popped while empty or during block generation");

  // The core releases right after its feed-forward cycle.
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.done |=> !core_stat.busy)
    else $error("core still busy after done");
`endif

endmodule
